[sv/aatm_pkg.sv]
package aatm_pkg;

	localparam int SAMPLE_W = 12;
	localparam int SUM_W = 17;
	localparam int CHANNELS = 4;
	localparam int DEF_FILTER_SIZE = 25;
	localparam int DIV_W = 42;
	localparam int DVS_W = 17;
	localparam int VAL_W = 26;

	typedef enum logic [2:0] {
		CFG_VREF_EN = 3'd0,
		CFG_VREF_CAL = 3'd1,
		CFG_PWM_PERIOD = 3'd2,
		CFG_POT_LIMIT = 3'd3,
		CFG_POT_HYST = 3'd4,
		CFG_TEMP_LIMIT = 3'd5,
		CFG_TEMP_HYST = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] pot_sample;
		logic [SAMPLE_W-1:0] ext_temp_sample;
		logic [SAMPLE_W-1:0] int_temp_sample;
		logic [SAMPLE_W-1:0] vref_sample;
	} in_t;

	typedef struct packed {
		logic [12:0] pot_mv;
		logic signed [15:0] ext_temp;
		logic signed [15:0] int_temp;
		logic pot_warning;
		logic ext_warning;
		logic int_warning;
		logic [1:0] warning_count;
		logic [15:0] pot_duty;
		logic [15:0] ext_duty;
		logic [15:0] int_duty;
		logic [12:0] ref_mv;
	} out_t;

	typedef struct packed {
		logic vref_correct_enable;
		logic [11:0] vref_calibration;
		logic [15:0] pwm_period;
		logic [12:0] pot_limit;
		logic [9:0] pot_hyst;
		logic signed [15:0] temp_limit;
		logic [9:0] temp_hyst;
	} cfg_t;

	typedef struct packed {
		logic [CHANNELS-1:0][SUM_W-1:0] sums;
	} job_t;

endpackage

[sv/aatm_queue.sv]
module aatm_queue import aatm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output job_t pop_job
);

	job_t mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

[sv/aatm_front.sv]
module aatm_front import aatm_pkg::*; #(
	parameter int FILTER_SIZE = DEF_FILTER_SIZE
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic push,
	output job_t push_job,
	input  logic queue_full
);

	localparam int CNT_W = $clog2(FILTER_SIZE + 1);

	logic [CHANNELS-1:0][SUM_W-1:0] sums_q;
	logic [CHANNELS-1:0][SUM_W-1:0] sums_next;
	logic [CNT_W-1:0] count_q;
	logic accept;
	logic last;

	assign in_ready = !queue_full;
	assign accept = in_valid && in_ready;
	assign last = (count_q == CNT_W'(FILTER_SIZE - 1));

	always_comb begin
		sums_next[0] = sums_q[0] + SUM_W'(in_data.pot_sample);
		sums_next[1] = sums_q[1] + SUM_W'(in_data.ext_temp_sample);
		sums_next[2] = sums_q[2] + SUM_W'(in_data.int_temp_sample);
		sums_next[3] = sums_q[3] + SUM_W'(in_data.vref_sample);
	end

	assign push = accept && last;
	assign push_job.sums = sums_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sums_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (last) begin
				sums_q <= '0;
				count_q <= '0;
			end else begin
				sums_q <= sums_next;
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

endmodule

[sv/aatm_div.sv]
module aatm_div import aatm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic done,
	output logic [DIV_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] work_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DVS_W:0] trial;
	logic fits;

	assign trial = {rem_q[DVS_W-1:0], work_q[DIV_W-1]};
	assign fits = (trial >= {1'b0, dvs_q});
	assign done = done_q;
	assign quotient = work_q;

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			work_q <= {work_q[DIV_W-2:0], fits};
			rem_q <= fits ? (trial - {1'b0, dvs_q}) : trial;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

[sv/aatm_back.sv]
module aatm_back import aatm_pkg::*; #(
	parameter int FILTER_SIZE = DEF_FILTER_SIZE
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic job_valid,
	input  job_t job,
	output logic job_pop,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	localparam logic [16:0] VREF_K = 17'(3300 * FILTER_SIZE);

	// Division by a constant d is done as (x * ceil(2^s / d)) >> s with s = 30 + clog2(d),
	// which is exact for every x below 2^30.
	localparam int SH_FS = 30 + $clog2(FILTER_SIZE);
	localparam int SH_10 = 30 + $clog2(10);
	localparam int SH_20 = 30 + $clog2(20);
	localparam int SH_25 = 30 + $clog2(25);
	localparam int SH_3000 = 30 + $clog2(3000);
	localparam int SH_400 = 30 + $clog2(400);
	localparam logic [30:0] RCP_FS =
		31'(((64'd1 << SH_FS) + 64'(FILTER_SIZE - 1)) / 64'(FILTER_SIZE));
	localparam logic [30:0] RCP_10 = 31'(((64'd1 << SH_10) + 64'd9) / 64'd10);
	localparam logic [30:0] RCP_20 = 31'(((64'd1 << SH_20) + 64'd19) / 64'd20);
	localparam logic [30:0] RCP_25 = 31'(((64'd1 << SH_25) + 64'd24) / 64'd25);
	localparam logic [30:0] RCP_3000 = 31'(((64'd1 << SH_3000) + 64'd2999) / 64'd3000);
	localparam logic [30:0] RCP_400 = 31'(((64'd1 << SH_400) + 64'd399) / 64'd400);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_MUL,
		ST_WAIT,
		ST_FLAGS,
		ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		STEP_REF = 4'd0,
		STEP_SC0 = 4'd1,
		STEP_SC1 = 4'd2,
		STEP_SC2 = 4'd3,
		STEP_POT = 4'd4,
		STEP_EXT = 4'd5,
		STEP_INT = 4'd6,
		STEP_D0 = 4'd7,
		STEP_D1 = 4'd8,
		STEP_D2 = 4'd9
	} step_t;

	state_t state_q;
	step_t step_q;
	logic [12:0] ref_q;
	logic [2:0] flags_q;
	logic [2:0][22:0] v_q;
	logic signed [VAL_W-1:0] pot_q;
	logic signed [VAL_W-1:0] ext_q;
	logic signed [VAL_W-1:0] int_q;
	logic [2:0][15:0] duty_q;
	logic [29:0] num_q;
	logic [60:0] prod_q;
	logic out_valid_q;
	out_t out_q;

	logic [DIV_W-1:0] dd;
	logic [DVS_W-1:0] dv;
	logic skip;
	logic div_start;
	logic div_done;
	logic [DIV_W-1:0] quot;
	logic [28:0] ref_num;
	logic [29:0] sc_num;
	logic [SUM_W-1:0] sc_sum;
	logic signed [VAL_W-1:0] int_diff;
	logic signed [VAL_W-1:0] int_m;
	logic signed [VAL_W-1:0] duty_src;
	logic signed [VAL_W-1:0] duty_span;
	logic signed [VAL_W-1:0] duty_diff;
	logic duty_sat;
	logic [27:0] duty_num;
	logic [30:0] cd_m;
	logic [60:0] cd_prod;
	logic [29:0] cd_q;
	logic [DIV_W-1:0] q_res;
	logic step_done;
	logic [33:0] v_scaled;
	logic signed [VAL_W-1:0] tlim;
	logic signed [VAL_W-1:0] plim;
	logic [2:0] flags_next;

	function automatic logic over_limit(input logic signed [VAL_W-1:0] v,
		input logic signed [VAL_W-1:0] lim, input logic [9:0] hy, input logic prev);
		logic signed [VAL_W-1:0] h;
		h = $signed({{(VAL_W-10){1'b0}}, hy});
		if (prev) begin
			return v > (lim - h);
		end
		return v >= (lim + h);
	endfunction

	assign ref_num = {12'd0, VREF_K} * {17'd0, cfg.vref_calibration};

	always_comb begin
		case (step_q)
			STEP_SC0: sc_sum = job.sums[0];
			STEP_SC1: sc_sum = job.sums[1];
			default: sc_sum = job.sums[2];
		endcase
	end
	assign sc_num = {13'd0, sc_sum} * {17'd0, ref_q};

	assign int_diff = $signed({3'd0, v_q[2]}) - VAL_W'(7600);
	assign int_m = int_diff * VAL_W'(10);

	always_comb begin
		case (step_q)
			STEP_D1: begin
				duty_src = ext_q - VAL_W'(200);
				duty_span = VAL_W'(400);
			end
			STEP_D2: begin
				duty_src = int_q - VAL_W'(200);
				duty_span = VAL_W'(400);
			end
			default: begin
				duty_src = pot_q;
				duty_span = VAL_W'(3000);
			end
		endcase
	end
	assign duty_diff = duty_src;
	// At or above the span the duty saturates at the period, so only a short
	// difference ever needs the product.
	assign duty_sat = (duty_diff >= duty_span);
	assign duty_num = {16'd0, duty_diff[11:0]} * {12'd0, cfg.pwm_period};

	always_comb begin
		dd = '0;
		dv = DVS_W'(1);
		skip = 1'b0;
		case (step_q)
			STEP_REF: begin
				dd = DIV_W'(ref_num);
				dv = job.sums[3];
				skip = !(cfg.vref_correct_enable && (job.sums[3] != '0));
			end
			STEP_SC0, STEP_SC1, STEP_SC2: begin
				dd = DIV_W'(sc_num);
			end
			STEP_POT: begin
				dd = DIV_W'(v_q[0]);
			end
			STEP_EXT: begin
				dd = DIV_W'(v_q[1]);
			end
			STEP_INT: begin
				dd = DIV_W'(int_m < 0 ? -int_m : int_m);
			end
			STEP_D0, STEP_D1, STEP_D2: begin
				dd = DIV_W'(duty_num);
				skip = (duty_diff <= 0) || duty_sat;
			end
			default: begin
				skip = 1'b1;
			end
		endcase
	end

	always_comb begin
		case (step_q)
			STEP_SC0, STEP_SC1, STEP_SC2: begin
				cd_m = RCP_FS;
				cd_q = 30'(prod_q >> SH_FS);
			end
			STEP_POT: begin
				cd_m = RCP_10;
				cd_q = 30'(prod_q >> SH_10);
			end
			STEP_EXT: begin
				cd_m = RCP_20;
				cd_q = 30'(prod_q >> SH_20);
			end
			STEP_INT: begin
				cd_m = RCP_25;
				cd_q = 30'(prod_q >> SH_25);
			end
			STEP_D0: begin
				cd_m = RCP_3000;
				cd_q = 30'(prod_q >> SH_3000);
			end
			default: begin
				cd_m = RCP_400;
				cd_q = 30'(prod_q >> SH_400);
			end
		endcase
	end
	assign cd_prod = {31'd0, num_q} * {30'd0, cd_m};
	assign q_res = (step_q == STEP_REF) ? quot : DIV_W'(cd_q);

	assign div_start = (state_q == ST_ISSUE) && !skip && (step_q == STEP_REF);
	assign step_done = (state_q == ST_ISSUE && skip)
		|| (state_q == ST_WAIT && (step_q != STEP_REF || div_done));
	assign v_scaled = q_res[29:0] * 34'd10;

	aatm_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(dd),
		.divisor(dv),
		.done(div_done),
		.quotient(quot)
	);

	assign tlim = VAL_W'($signed(cfg.temp_limit));
	assign plim = $signed({{(VAL_W-13){1'b0}}, cfg.pot_limit});
	assign flags_next[0] = over_limit(pot_q, plim, cfg.pot_hyst, flags_q[0]);
	assign flags_next[1] = over_limit(ext_q, tlim, cfg.temp_hyst, flags_q[1]);
	assign flags_next[2] = over_limit(int_q, tlim, cfg.temp_hyst, flags_q[2]);

	assign job_pop = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// A step finishes by skipping in ST_ISSUE, or in ST_WAIT once its quotient is ready.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= STEP_REF;
			ref_q <= 13'd3000;
			flags_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						step_q <= STEP_REF;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE, ST_WAIT: begin
					if (step_done) begin
						case (step_q)
							STEP_REF: begin
								if (!skip) begin
									ref_q <= (quot > DIV_W'(8191)) ? 13'd8191 : quot[12:0];
								end
							end
							STEP_SC0: v_q[0] <= 23'(v_scaled[33:12]);
							STEP_SC1: v_q[1] <= 23'(v_scaled[33:12]);
							STEP_SC2: v_q[2] <= 23'(v_scaled[33:12]);
							STEP_POT: pot_q <= VAL_W'(q_res);
							STEP_EXT: ext_q <= VAL_W'(1010) - VAL_W'(q_res);
							STEP_INT: begin
								int_q <= int_m < 0 ? VAL_W'(250) - VAL_W'(q_res)
									: VAL_W'(250) + VAL_W'(q_res);
							end
							STEP_D0, STEP_D1, STEP_D2: begin
								duty_q[2'(step_q - STEP_D0)] <= !skip ? q_res[15:0]
									: duty_sat ? cfg.pwm_period : 16'd0;
							end
							default: begin
							end
						endcase
						if (step_q == STEP_INT) begin
							state_q <= ST_FLAGS;
						end else if (step_q == STEP_D2) begin
							state_q <= ST_OUT;
						end else begin
							step_q <= step_t'(step_q + 4'd1);
							state_q <= ST_ISSUE;
						end
					end else if (state_q == ST_ISSUE) begin
						num_q <= dd[29:0];
						state_q <= (step_q == STEP_REF) ? ST_WAIT : ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q <= cd_prod;
					state_q <= ST_WAIT;
				end
				ST_FLAGS: begin
					flags_q <= flags_next;
					step_q <= STEP_D0;
					state_q <= ST_ISSUE;
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_q.pot_mv <= pot_q[12:0];
						out_q.ext_temp <= ext_q[15:0];
						out_q.int_temp <= int_q[15:0];
						out_q.pot_warning <= flags_q[0];
						out_q.ext_warning <= flags_q[1];
						out_q.int_warning <= flags_q[2];
						out_q.warning_count <= 2'(flags_q[0]) + 2'(flags_q[1])
							+ 2'(flags_q[2]);
						out_q.pot_duty <= duty_q[0];
						out_q.ext_duty <= duty_q[1];
						out_q.int_duty <= duty_q[2];
						out_q.ref_mv <= ref_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[sv/adc_average_threshold_monitor.sv]
// ADC averaging and threshold monitor.
// The in channel takes one frame of four 12-bit ADC codes per beat; a frame is
// taken every cycle while the job queue between front end and back end has room.
// After FILTER_SIZE frames the per-channel sums go into a two-entry queue and the
// back end turns them into one result beat on the out channel; other frames give
// no result.
// The reference correction runs on a 42-bit restoring divider; every other
// division is by a constant and is done by reciprocal multiplication.
// Blocks that arrive faster than the back end finishes them are absorbed by the
// queue and then stall the in channel; the front end keeps summing the next
// block while the back end works on the one before it.
// A finished result waits in the output register while out_ready is low; the
// back end finishes the next block meanwhile and the front end keeps taking
// frames until the queue fills.
// Reset clears sums, flags and the queue, sets the reference to 3000 mV and the
// registers to their defaults. The cfg channel is always ready; write registers
// only while the block is idle.
module adc_average_threshold_monitor import aatm_pkg::*; #(
	parameter int FILTER_SIZE = DEF_FILTER_SIZE
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t cfg_q;
	logic push;
	job_t push_job;
	logic queue_full;
	logic job_valid;
	job_t job;
	logic job_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vref_correct_enable <= 1'b1;
			cfg_q.vref_calibration <= 12'd1500;
			cfg_q.pwm_period <= 16'd1000;
			cfg_q.pot_limit <= 13'd1500;
			cfg_q.pot_hyst <= 10'd100;
			cfg_q.temp_limit <= 16'sd400;
			cfg_q.temp_hyst <= 10'd10;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_VREF_EN: cfg_q.vref_correct_enable <= cfg_data[0];
				CFG_VREF_CAL: cfg_q.vref_calibration <= cfg_data[11:0];
				CFG_PWM_PERIOD: cfg_q.pwm_period <= cfg_data;
				CFG_POT_LIMIT: cfg_q.pot_limit <= cfg_data[12:0];
				CFG_POT_HYST: cfg_q.pot_hyst <= cfg_data[9:0];
				CFG_TEMP_LIMIT: cfg_q.temp_limit <= cfg_data;
				CFG_TEMP_HYST: cfg_q.temp_hyst <= cfg_data[9:0];
				default: begin
				end
			endcase
		end
	end

	aatm_front #(.FILTER_SIZE(FILTER_SIZE)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.push(push),
		.push_job(push_job),
		.queue_full(queue_full)
	);

	aatm_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.full(queue_full),
		.pop(job_pop),
		.not_empty(job_valid),
		.pop_job(job)
	);

	aatm_back #(.FILTER_SIZE(FILTER_SIZE)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.job_valid(job_valid),
		.job(job),
		.job_pop(job_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

endmodule

[tb/sv/adc_average_threshold_monitor_tb.sv]
module adc_average_threshold_monitor_tb;
	import aatm_pkg::*;

	localparam int FRAMES = DEF_FILTER_SIZE;
	localparam int SETTLE = 600;
	localparam int CYCLE_LIMIT = 600000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	adc_average_threshold_monitor dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Mirror of the block's registers and state.
	cfg_t regs_now;
	logic [SUM_W-1:0] sum_acc [CHANNELS];
	int frames_in_block;
	logic [12:0] ref_now;
	logic [2:0] flags_now;

	out_t pending_results [$];
	int errors = 0;
	int cycles = 0;
	int blocks_sent = 0;
	int results_seen = 0;
	int phases_run = 0;
	bit burst_mode = 1'b0;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL adc_average_threshold_monitor");
			$finish;
		end
	end

	function automatic bit hyst_flag(longint v, longint lim, longint hy, bit prev);
		if (prev)
			return v > lim - hy;
		return v >= lim + hy;
	endfunction

	function automatic logic [15:0] duty_from(longint v, longint base, longint span);
		longint p;
		longint d;
		p = longint'(regs_now.pwm_period);
		d = (v - base) * p / span;
		if (d < 0)
			d = 0;
		if (d > p)
			d = p;
		return d[15:0];
	endfunction

	function automatic out_t block_result();
		out_t r;
		longint s;
		longint rv;
		longint v [CHANNELS];
		longint pot;
		longint ext;
		longint itemp;
		longint tlim;
		if (regs_now.vref_correct_enable && sum_acc[CHANNELS-1] != 0) begin
			rv = 64'd3300 * FRAMES * longint'(regs_now.vref_calibration)
				/ longint'(sum_acc[CHANNELS-1]);
			ref_now = (rv > 8191) ? 13'd8191 : rv[12:0];
		end
		for (int i = 0; i < CHANNELS; i++) begin
			s = longint'(sum_acc[i]) * longint'(ref_now) / FRAMES;
			v[i] = (s * 10) >>> 12;
		end
		pot = v[0] / 10;
		ext = -(v[1] / 20) + 1010;
		itemp = (v[2] - 7600) * 10 / 25 + 250;
		tlim = longint'($signed(regs_now.temp_limit));
		flags_now[0] = hyst_flag(pot, regs_now.pot_limit, regs_now.pot_hyst, flags_now[0]);
		flags_now[1] = hyst_flag(ext, tlim, regs_now.temp_hyst, flags_now[1]);
		flags_now[2] = hyst_flag(itemp, tlim, regs_now.temp_hyst, flags_now[2]);
		r.pot_mv = pot[12:0];
		r.ext_temp = ext[15:0];
		r.int_temp = itemp[15:0];
		r.pot_warning = flags_now[0];
		r.ext_warning = flags_now[1];
		r.int_warning = flags_now[2];
		r.warning_count = 2'(flags_now[0]) + 2'(flags_now[1]) + 2'(flags_now[2]);
		r.pot_duty = duty_from(pot, 0, 3000);
		r.ext_duty = duty_from(ext, 200, 400);
		r.int_duty = duty_from(itemp, 200, 400);
		r.ref_mv = ref_now;
		return r;
	endfunction

	function automatic int pick_gap();
		if (burst_mode || $urandom_range(0, 9) < 5)
			return 0;
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(4, 60);
	endfunction

	task automatic send_frame(in_t f);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= f;
		do @(posedge clk); while (!in_ready);
		sum_acc[0] = sum_acc[0] + f.pot_sample;
		sum_acc[1] = sum_acc[1] + f.ext_temp_sample;
		sum_acc[2] = sum_acc[2] + f.int_temp_sample;
		sum_acc[3] = sum_acc[3] + f.vref_sample;
		frames_in_block++;
		if (frames_in_block == FRAMES) begin
			pending_results.push_back(block_result());
			for (int i = 0; i < CHANNELS; i++)
				sum_acc[i] = '0;
			frames_in_block = 0;
			blocks_sent++;
		end
	endtask

	task automatic end_of_stream();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_VREF_EN: regs_now.vref_correct_enable = val[0];
			CFG_VREF_CAL: regs_now.vref_calibration = val[11:0];
			CFG_PWM_PERIOD: regs_now.pwm_period = val;
			CFG_POT_LIMIT: regs_now.pot_limit = val[12:0];
			CFG_POT_HYST: regs_now.pot_hyst = val[9:0];
			CFG_TEMP_LIMIT: regs_now.temp_limit = val;
			CFG_TEMP_HYST: regs_now.temp_hyst = val[9:0];
			default: ;
		endcase
	endtask

	task automatic apply_config(logic [15:0] en, logic [15:0] cal, logic [15:0] per,
			logic [15:0] plim, logic [15:0] phy, logic [15:0] tlim, logic [15:0] thy);
		write_reg(CFG_VREF_EN, en);
		write_reg(CFG_VREF_CAL, cal);
		write_reg(CFG_PWM_PERIOD, per);
		write_reg(CFG_POT_LIMIT, plim);
		write_reg(CFG_POT_HYST, phy);
		write_reg(CFG_TEMP_LIMIT, tlim);
		write_reg(CFG_TEMP_HYST, thy);
		phases_run++;
	endtask

	function automatic logic [11:0] near(int center);
		int x;
		x = center + $urandom_range(0, 40) - 20;
		if (x < 0)
			x = 0;
		if (x > 4095)
			x = 4095;
		return x[11:0];
	endfunction

	// Most blocks look like real sensor data around a level picked anew for each block so the
	// warning flags and duties move through their working range.
	task automatic run_blocks(int count);
		int mode;
		int c_pot;
		int c_ext;
		int c_int;
		int c_ref;
		int target;
		in_t f;
		for (int b = 0; b < count; b++) begin
			mode = $urandom_range(0, 9);
			burst_mode = ($urandom_range(0, 3) == 0);
			c_pot = $urandom_range(0, 4095);
			c_ext = $urandom_range(900, 2400);
			c_int = $urandom_range(950, 1250);
			target = $urandom_range(2500, 3600);
			c_ref = 3300 * regs_now.vref_calibration / target;
			for (int k = 0; k < FRAMES; k++) begin
				if (mode == 0) begin
					f = in_t'({$urandom, $urandom});
				end else begin
					f.pot_sample = near(c_pot);
					f.ext_temp_sample = near(c_ext);
					f.int_temp_sample = near(c_int);
					f.vref_sample = (mode == 1) ? 12'd0 : near(c_ref);
				end
				send_frame(f);
			end
		end
		end_of_stream();
	endtask

	task automatic test_directed_extremes();
		in_t f;
		for (int k = 0; k < FRAMES; k++) begin
			case (k % 3)
				0: f = '1;
				1: f = '0;
				default: f = in_t'({$urandom, $urandom});
			endcase
			send_frame(f);
		end
		end_of_stream();
	endtask

	task automatic test_default_settings();
		apply_config(1, 1500, 1000, 1500, 100, 400, 10);
		run_blocks(6);
	endtask

	task automatic test_maximum_settings();
		apply_config(1, 4095, 16'hFFFF, 8191, 1023, 16'h7FFF, 1023);
		run_blocks(6);
	endtask

	task automatic test_minimum_settings();
		apply_config(0, 0, 0, 0, 0, 16'hF000, 0);
		run_blocks(6);
	endtask

	task automatic test_zero_calibration();
		apply_config(1, 0, 1000, 1500, 100, 400, 10);
		run_blocks(4);
	endtask

	task automatic test_correction_off();
		apply_config(1, 1500, 1000, 1500, 100, 400, 10);
		run_blocks(2);
		apply_config(0, 1500, 1, 1500, 100, 16'h8000, 1023);
		run_blocks(6);
	endtask

	task automatic test_random_settings();
		for (int p = 0; p < 3; p++) begin
			apply_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom), 16'($urandom));
			run_blocks(3);
		end
		apply_config(1, 16'($urandom_range(1200, 1800)), 16'($urandom_range(1, 65535)),
			16'($urandom_range(1000, 2500)), 16'($urandom_range(0, 200)),
			16'($urandom_range(250, 550)), 16'($urandom_range(0, 50)));
		run_blocks(10);
	endtask

	task automatic check_field(string name, longint exp_v, longint got_v);
		if (exp_v != got_v) begin
			errors++;
			$display("%0t: mismatch %s expected %0d actual %0d", $time, name, exp_v, got_v);
		end
	endtask

	// Result side: random back-pressure, checked against the oldest prediction.
	int stall_left = 0;
	always @(posedge clk) begin
		out_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat, actual %h", $time, out_data);
			end else begin
				exp_r = pending_results.pop_front();
				check_field("pot_mv", exp_r.pot_mv, out_data.pot_mv);
				check_field("ext_temp", exp_r.ext_temp, out_data.ext_temp);
				check_field("int_temp", exp_r.int_temp, out_data.int_temp);
				check_field("pot_warning", exp_r.pot_warning, out_data.pot_warning);
				check_field("ext_warning", exp_r.ext_warning, out_data.ext_warning);
				check_field("int_warning", exp_r.int_warning, out_data.int_warning);
				check_field("warning_count", exp_r.warning_count, out_data.warning_count);
				check_field("pot_duty", exp_r.pot_duty, out_data.pot_duty);
				check_field("ext_duty", exp_r.ext_duty, out_data.ext_duty);
				check_field("int_duty", exp_r.int_duty, out_data.int_duty);
				check_field("ref_mv", exp_r.ref_mv, out_data.ref_mv);
			end
		end
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (!burst_mode && $urandom_range(0, 9) < 3) begin
			stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
				: $urandom_range(4, 300);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin
		regs_now = '{vref_correct_enable: 1'b1, vref_calibration: 12'd1500,
			pwm_period: 16'd1000, pot_limit: 13'd1500, pot_hyst: 10'd100,
			temp_limit: 16'sd400, temp_hyst: 10'd10};
		for (int i = 0; i < CHANNELS; i++)
			sum_acc[i] = '0;
		frames_in_block = 0;
		ref_now = 13'd3000;
		flags_now = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		test_default_settings();
		test_maximum_settings();
		test_minimum_settings();
		test_zero_calibration();
		test_correction_off();
		test_random_settings();
		$display("Covered %0d blocks (%0d results) over %0d register settings,", blocks_sent,
			results_seen, phases_run);
		$display("with random gaps on frames and random back-pressure on results.");
		if (errors == 0 && pending_results.size() == 0) begin
			$display("PASS adc_average_threshold_monitor");
		end else begin
			$display("FAIL adc_average_threshold_monitor");
		end
		$finish;
	end

endmodule

[files.f]
sv/aatm_pkg.sv
sv/aatm_queue.sv
sv/aatm_front.sv
sv/aatm_div.sv
sv/aatm_back.sv
sv/adc_average_threshold_monitor.sv
tb/sv/adc_average_threshold_monitor_tb.sv
